@@ rtl/core/timed_event_queue_assert.svh @@
// Assertion macros used by the timed event queue RTL.
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timed event queue: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timed event queue: next-cycle check failed");

`endif

@@ rtl/core/teq_pkg.sv @@
package teq_pkg;

  // Queue geometry and field widths.
  localparam int CAPACITY = 6;
  localparam int NUM_IDS  = 16;
  localparam int TIME_W   = 32;
  localparam int ID_W     = $clog2(NUM_IDS);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STATUS_W = 2;

  // Input commands.
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_CHECK    = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_SCHEDULED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FIRED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

  // Operation applied to every cell of the chain in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_REMOVE = 2'd1,
    CELL_POP    = 2'd2,
    CELL_INSERT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [TIME_W-1:0]   new_time;
    logic [ID_W-1:0]     new_id;
  } cell_ctl_t;

  // True when a is strictly earlier than b, modulo 2^TIME_W.
  function automatic logic time_before(input logic [TIME_W-1:0] a,
                                       input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return diff[TIME_W-1];
  endfunction

endpackage

@@ rtl/core/timed_event_queue.sv @@
// Channel  | Direction | Ports                                   | Handshake
// in       | input     | in_command, in_time_value, in_task_id   | in_valid / in_ready
// out      | output    | out_status, out_fired_id, out_occupancy | out_valid / out_ready
//
// A check or a refused schedule completes at its accept edge.
// A schedule is done in two steps: removal of the same id through the cell chain at
// the accept edge, then the sorted insertion through the chain in the next cycle.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
// An item is taken only when the result register is empty or draining that cycle,
// so a stalled out channel holds off the input side.
`include "timed_event_queue_assert.svh"

module timed_event_queue import teq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [TIME_W-1:0]   in_time_value,
  input  logic [ID_W-1:0]     in_task_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [ID_W-1:0]     out_fired_id,
  output logic [CNT_W-1:0]    out_occupancy
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_INSERT = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TIME_W-1:0]   hold_time_r, hold_time_nxt;
  logic [ID_W-1:0]     hold_id_r, hold_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_fired_id_r, out_fired_id_nxt;
  logic [CNT_W-1:0]    out_occ_r, out_occ_nxt;

  cell_ctl_t           ctl;
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY:0]   chain;
  logic [TIME_W-1:0]   cell_time [CAPACITY];
  logic [ID_W-1:0]     cell_id [CAPACITY];
  logic                in_fire;
  logic                out_free;
  logic                head_due;
  logic [TIME_W-1:0]   head_diff;

  // The cell chain.
  assign chain[0] = 1'b0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [TIME_W-1:0] l_time, r_time;
    logic [ID_W-1:0]   l_id, r_id;

    assign valid_vec[k] = (CNT_W'(k) < count_r);

    if (k == 0) begin : g_first
      assign l_time = cell_time[k];
      assign l_id   = cell_id[k];
    end else begin : g_mid_l
      assign l_time = cell_time[k-1];
      assign l_id   = cell_id[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign r_time = cell_time[k];
      assign r_id   = cell_id[k];
    end else begin : g_mid_r
      assign r_time = cell_time[k+1];
      assign r_id   = cell_id[k+1];
    end

    teq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid_i    (valid_vec[k]),
      .left_time  (l_time),
      .left_id    (l_id),
      .right_time (r_time),
      .right_id   (r_id),
      .chain_in   (chain[k]),
      .chain_out  (chain[k+1]),
      .time_o     (cell_time[k]),
      .id_o       (cell_id[k])
    );
  end

  // Handshake.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  // Head is due when its time minus the current time is zero or negative.
  assign head_diff = cell_time[0] - in_time_value;
  assign head_due  = (count_r != '0) && ((head_diff == '0) || head_diff[TIME_W-1]);

  // Command sequencing.
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    hold_time_nxt    = hold_time_r;
    hold_id_nxt      = hold_id_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_status_nxt   = out_status_r;
    out_fired_id_nxt = out_fired_id_r;
    out_occ_nxt      = out_occ_r;
    ctl.op           = CELL_HOLD;
    ctl.new_time     = hold_time_r;
    ctl.new_id       = hold_id_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ctl.new_time = in_time_value;
          ctl.new_id   = in_task_id;
          if (in_command == CMD_CHECK) begin
            out_valid_nxt    = 1'b1;
            out_fired_id_nxt = '0;
            out_status_nxt   = ST_NONE_DUE;
            if (head_due) begin
              ctl.op           = CELL_POP;
              count_nxt        = count_r - 1'b1;
              out_status_nxt   = ST_FIRED;
              out_fired_id_nxt = cell_id[0];
            end
            out_occ_nxt = count_nxt;
          end else if (count_r == CNT_W'(CAPACITY)) begin
            out_valid_nxt    = 1'b1;
            out_status_nxt   = ST_OVERFLOW;
            out_fired_id_nxt = '0;
            out_occ_nxt      = count_r;
          end else begin
            ctl.op        = CELL_REMOVE;
            count_nxt     = count_r - CNT_W'(chain[CAPACITY]);
            hold_time_nxt = in_time_value;
            hold_id_nxt   = in_task_id;
            state_nxt     = S_INSERT;
          end
        end
      end
      S_INSERT: begin
        ctl.op           = CELL_INSERT;
        count_nxt        = count_r + 1'b1;
        out_valid_nxt    = 1'b1;
        out_status_nxt   = ST_SCHEDULED;
        out_fired_id_nxt = '0;
        out_occ_nxt      = count_nxt;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hold_time_r    <= hold_time_nxt;
    hold_id_r      <= hold_id_nxt;
    out_status_r   <= out_status_nxt;
    out_fired_id_r <= out_fired_id_nxt;
    out_occ_r      <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_fired_id  = out_fired_id_r;
  assign out_occupancy = out_occ_r;

  // Checks on the queue control.
  `TEQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `TEQ_ASSERT_NOW(a_insert_slot_free, clk, rst_n, state_r == S_INSERT, !out_valid_r)
  `TEQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, state_r == S_INSERT,
                   count_r == $past(count_r) + 1'b1)
  `TEQ_ASSERT_NEXT(a_empty_check, clk, rst_n,
                   in_fire && in_command == CMD_CHECK && count_r == '0,
                   out_valid_r && out_status_r == ST_NONE_DUE)

endmodule

@@ rtl/core/teq_cell.sv @@
module teq_cell import teq_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              valid_i,
  input  logic [TIME_W-1:0] left_time,
  input  logic [ID_W-1:0]   left_id,
  input  logic [TIME_W-1:0] right_time,
  input  logic [ID_W-1:0]   right_id,
  input  logic              chain_in,
  output logic              chain_out,
  output logic [TIME_W-1:0] time_o,
  output logic [ID_W-1:0]   id_o
);

  logic [TIME_W-1:0] time_r, time_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              cond;

  // The chain flag tells each cell whether the change point lies at or before it.
  always_comb begin
    time_nxt  = time_r;
    id_nxt    = id_r;
    chain_out = chain_in;
    cond      = 1'b0;
    case (ctl.op)
      CELL_REMOVE: begin
        cond      = valid_i && (id_r == ctl.new_id);
        chain_out = chain_in | cond;
        if (chain_out) begin
          time_nxt = right_time;
          id_nxt   = right_id;
        end
      end
      CELL_POP: begin
        chain_out = 1'b1;
        time_nxt  = right_time;
        id_nxt    = right_id;
      end
      CELL_INSERT: begin
        cond      = !valid_i || time_before(ctl.new_time, time_r);
        chain_out = chain_in | cond;
        if (chain_in) begin
          time_nxt = left_time;
          id_nxt   = left_id;
        end else if (cond) begin
          time_nxt = ctl.new_time;
          id_nxt   = ctl.new_id;
        end
      end
      default: begin
        chain_out = chain_in;
      end
    endcase
  end

  // Entry storage; contents are meaningful only below the fill count.
  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    id_r   <= id_nxt;
  end

  assign time_o = time_r;
  assign id_o   = id_r;

endmodule

@@ tb/teq_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the timed event queue, keeps its own copy of the
// sorted queue, and compares every result against the predicted report.
module teq_checker import teq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_command,
  input  logic [TIME_W-1:0]   in_time_value,
  input  logic [ID_W-1:0]     in_task_id,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [ID_W-1:0]     out_fired_id,
  input  logic [CNT_W-1:0]    out_occupancy,
  output int unsigned         mismatch_count,
  output int unsigned         reports_owed
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     fired_id;
    logic [CNT_W-1:0]    occupancy;
  } queue_report_t;

  // Shadow copy of the pending events, earliest first.
  logic [TIME_W-1:0] slot_time [CAPACITY];
  logic [ID_W-1:0]   slot_id   [CAPACITY];
  int                slot_count = 0;

  queue_report_t pending_reports [$];
  int unsigned   faults = 0;

  // Wrap-aware ordering: a is earlier than b when a - b is negative.
  function automatic bit precedes(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] gap;
    gap = a - b;
    return gap[TIME_W-1];
  endfunction

  // Remove one event and close the hole behind it.
  function automatic void drop_slot(input int pos);
    int k;
    for (k = pos; k + 1 < slot_count; k++) begin
      slot_time[k] = slot_time[k + 1];
      slot_id[k]   = slot_id[k + 1];
    end
    slot_count--;
  endfunction

  // Apply one command to the shadow queue and return the report it yields.
  function automatic queue_report_t advance_timer_queue(input logic cmd,
                                                        input logic [TIME_W-1:0] t,
                                                        input logic [ID_W-1:0] id);
    queue_report_t     rep;
    int                k;
    int                pos;
    int                hit;
    logic [TIME_W-1:0] lead;
    rep.fired_id = '0;
    if (cmd == CMD_SCHEDULE) begin
      if (slot_count >= CAPACITY) begin
        // A full queue refuses the event, even a reschedule of a pending id.
        rep.status = ST_OVERFLOW;
      end else begin
        hit = -1;
        for (k = 0; k < slot_count; k++) begin
          if (hit < 0 && slot_id[k] == id) hit = k;
        end
        if (hit >= 0) drop_slot(hit);
        // Equal times go behind the ones already queued.
        pos = 0;
        while (pos < slot_count && !precedes(t, slot_time[pos])) pos++;
        for (k = slot_count; k > pos; k--) begin
          slot_time[k] = slot_time[k - 1];
          slot_id[k]   = slot_id[k - 1];
        end
        slot_time[pos] = t;
        slot_id[pos]   = id;
        slot_count++;
        rep.status = ST_SCHEDULED;
      end
    end else begin
      rep.status = ST_NONE_DUE;
      if (slot_count > 0) begin
        lead = slot_time[0] - t;
        if (lead == '0 || lead[TIME_W-1]) begin
          rep.fired_id = slot_id[0];
          rep.status   = ST_FIRED;
          drop_slot(0);
        end
      end
    end
    rep.occupancy = slot_count[CNT_W-1:0];
    return rep;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      faults++;
    end
  endtask

  // Predict on every accepted item, compare on every accepted result.
  always @(posedge clk) begin : watch_channels
    queue_report_t want;
    if (!rst_n) begin
      slot_count = 0;
      pending_reports.delete();
    end else begin
      if (in_valid && in_ready) begin
        pending_reports.push_back(advance_timer_queue(in_command, in_time_value, in_task_id));
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("result with nothing outstanding: status %0d, fired_id %0d, occupancy %0d",
                 out_status, out_fired_id, out_occupancy);
          faults++;
        end else begin
          want = pending_reports.pop_front();
          check_field("status", want.status, out_status);
          check_field("fired_id", want.fired_id, out_fired_id);
          check_field("occupancy", want.occupancy, out_occupancy);
        end
      end
    end
    mismatch_count <= faults;
    reports_owed   <= pending_reports.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import teq_pkg::*;

  localparam int RANDOM_ITEMS    = 430;
  localparam int HOLD_OFF_CYCLES = 90;
  localparam int DRAIN_CYCLES    = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_command;
  logic [TIME_W-1:0]   in_time_value;
  logic [ID_W-1:0]     in_task_id;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_fired_id;
  logic [CNT_W-1:0]    out_occupancy;
  int unsigned         mismatch_count;
  int unsigned         reports_owed;

  // Items left in the current sender burst.
  int unsigned burst_left = 0;

  // Time base that the random schedule and check commands follow.
  logic [TIME_W-1:0] clock_ms;
  logic [TIME_W-1:0] last_due;

  timed_event_queue DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_time_value (in_time_value),
    .in_task_id    (in_task_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_fired_id  (out_fired_id),
    .out_occupancy (out_occupancy)
  );

  teq_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_time_value  (in_time_value),
    .in_task_id     (in_task_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_fired_id   (out_fired_id),
    .out_occupancy  (out_occupancy),
    .mismatch_count (mismatch_count),
    .reports_owed   (reports_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one item, wait for it to be taken, then pace the sender in bursts.
  task automatic offer(input logic cmd, input logic [TIME_W-1:0] t,
                       input logic [ID_W-1:0] id);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_time_value <= t;
    in_task_id    <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // Now and then a long run with no gaps at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
  endtask

  task automatic schedule_event(input logic [TIME_W-1:0] t, input logic [ID_W-1:0] id);
    offer(CMD_SCHEDULE, t, id);
  endtask

  // The id field is ignored on a check, so it carries noise.
  task automatic check_due(input logic [TIME_W-1:0] t);
    offer(CMD_CHECK, t, ID_W'($urandom));
  endtask

  // Reset, directed cases, then random episodes.
  initial begin
    int unsigned sent;
    int unsigned episode_len;
    int unsigned id_pool;
    int unsigned sched_pct;
    int unsigned pick;
    logic [TIME_W-1:0] due;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_command    <= CMD_SCHEDULE;
    in_time_value <= '0;
    in_task_id    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue, equal times, reschedule, and due exactly on time.
    check_due(32'h0000_0000);
    schedule_event(32'd100, 4'd3);
    schedule_event(32'd100, 4'd5);
    schedule_event(32'd50, 4'd3);
    check_due(32'd49);
    check_due(32'd50);
    // Fill the queue with times around the wrap point and the sign boundary.
    schedule_event(32'hFFFF_FFFF, 4'd0);
    schedule_event(32'h7FFF_FFFF, 4'd15);
    schedule_event(32'h8000_0000, 4'd9);
    schedule_event(32'h0000_0000, 4'd10);
    schedule_event(32'hFFFF_FFF0, 4'd12);
    // Full queue: a new id and a pending id are both refused.
    schedule_event(32'd100, 4'd6);
    schedule_event(32'd1, 4'd5);
    // Drain with check times on both sides of the wrap.
    check_due(32'h0000_0010);
    check_due(32'h7FFF_FFFF);
    check_due(32'h8000_0000);
    check_due(32'hFFFF_FFFF);
    check_due(32'h0000_0000);
    check_due(32'h0000_0064);
    check_due(32'hFFFF_FFFF);
    check_due(32'h7FFF_FFFF);
    check_due(32'h8000_0000);

    // Random episodes: each picks an id pool and a mix of schedules and checks.
    clock_ms = $urandom;
    last_due = clock_ms;
    sent     = 0;
    while (sent < RANDOM_ITEMS) begin
      episode_len = $urandom_range(10, 40);
      pick        = $urandom_range(0, 2);
      id_pool     = (pick == 0) ? 2 : (pick == 1) ? 4 : NUM_IDS;
      sched_pct   = 30 + 20 * $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 200);
      repeat (episode_len) begin
        if ($urandom_range(0, 99) < sched_pct) begin
          pick = $urandom_range(0, 19);
          if (pick < 13)      due = clock_ms + $urandom_range(0, 200);
          else if (pick < 16) due = clock_ms - $urandom_range(0, 100);
          else if (pick < 19) due = last_due;
          else                due = $urandom;
          last_due = due;
          schedule_event(due, ID_W'($urandom_range(0, id_pool - 1)));
        end else begin
          clock_ms = clock_ms + $urandom_range(0, 60);
          if ($urandom_range(0, 15) == 0) check_due($urandom);
          else check_due(clock_ms);
        end
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Let the last accept land in the checker, then wait for every report.
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && reports_owed == 0) begin
      $display("[timed_event_queue] OK");
    end else begin
      $display("[timed_event_queue] ERROR");
    end
    $finish;
  end

  // Result side: stretches of different stall patterns, two long hold-offs.
  initial begin
    int unsigned stretch;
    int unsigned mode;
    int unsigned ready_pct;
    out_ready <= 1'b0;
    wait (rst_n);
    stretch = 0;
    forever begin
      if (stretch == 4 || stretch == 30) begin
        // Hold off long enough for the queue to back up into the input.
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      ready_pct = (mode == 0) ? 100 : (mode == 1) ? 50 : (mode == 2) ? 85 : 25;
      repeat ($urandom_range(20, 60)) begin
        out_ready <= ($urandom_range(0, 99) < ready_pct);
        @(posedge clk);
      end
      stretch++;
    end
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #1_000_000;
    $display("[timed_event_queue] ERROR");
    $finish;
  end

endmodule
